/* hdl/chist_pkg.sv */
// Shared types, constants and helpers of the cumulative bucket histogram.
`default_nettype none
package chist_pkg;

  localparam int MAX_BUCKETS = 16;
  localparam int SAMPLE_BITS = 32;
  localparam int IDX_W       = $clog2(MAX_BUCKETS);
  localparam int NUM_W       = $clog2(MAX_BUCKETS + 1);
  localparam int CFG_W       = 5;
  localparam int CNT_W       = 32;
  localparam int VAL_W       = 32;
  localparam int SUM_W       = 48;
  localparam int PADDR_W     = 3;

  localparam longint RANGE_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam longint RANGE_LO = -RANGE_HI - 64'sd1;

  localparam logic REG_BUCKETS = 1'b0;

  typedef enum logic [1:0] {
    OP_OBSERVE = 2'd0,
    OP_WRITE   = 2'd1,
    OP_READ    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_BUCKETS = 2'd1,
    ST_BAD        = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WCHK,
    S_RESP
  } state_e;

  typedef struct packed {
    op_e               op;
    logic signed [31:0] value;
    logic [3:0]        index;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [31:0]        total_count;
    logic signed [47:0] running_sum;
    logic [31:0]        bucket_value;
  } out_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic [CNT_W-1:0]        cnt;
  } alu_req_t;

  typedef struct packed {
    logic             le;
    logic [CNT_W-1:0] cnt_inc;
  } alu_rsp_t;

  function automatic logic in_range(logic signed [VAL_W-1:0] v);
    longint w;
    w = longint'(v);
    return (w <= RANGE_HI) && (w >= RANGE_LO);
  endfunction

  function automatic logic signed [VAL_W-1:0] clamp_sample(logic signed [VAL_W-1:0] v);
    longint w;
    logic signed [VAL_W-1:0] r;
    w = longint'(v);
    if (w > RANGE_HI) begin
      r = VAL_W'(RANGE_HI);
    end else if (w < RANGE_LO) begin
      r = VAL_W'(RANGE_LO);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/chist_alu.sv */
// Shared compare and saturating increment unit of the histogram sequencer.
`default_nettype none
module chist_alu
  import chist_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  assign rsp_o.le      = (req_i.a <= req_i.b);
  assign rsp_o.cnt_inc = (&req_i.cnt) ? req_i.cnt : req_i.cnt + CNT_W'(1);

endmodule
`default_nettype wire

/* hdl/cumulative_bucket_histogram_top.sv */
// Cumulative bucket histogram: sequencer, bound and bucket tables, APB register.
// Observe: S_SCAN steps over the buckets in use, one bucket per cycle through the
// shared compare/increment unit; S_RESP loads the result into the output register.
// Write bound goes via S_WCHK for a nonzero index and in-range value; read and clear go
// to S_RESP. Input is taken again once the result is loaded; a stalled result holds it.
// Reset (async, active low) clears count, sum, register and bucket valid bits;
// bound table is undefined until written.
`default_nettype none
module cumulative_bucket_histogram_top
  import chist_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire in_item_t           in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      out_item_t          out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);

  state_e state_q, state_d;

  logic [CFG_W-1:0]        cfg_q;
  logic [NUM_W-1:0]        num_act;
  logic [IDX_W-1:0]        cnt_q, cnt_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  op_e                     op_q, op_d;
  status_e                 status_q, status_d;
  logic [CNT_W-1:0]        total_q, total_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_q, out_d;

  logic signed [VAL_W-1:0] bound_mem [MAX_BUCKETS];
  logic signed [VAL_W-1:0] bound_rd_q;
  logic [CNT_W-1:0]        bucket_mem [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0]  bkt_vld_q;
  logic [CNT_W-1:0]        bucket_rd_q;

  logic                    bnd_we, bkt_we, bkt_clr;
  logic [IDX_W-1:0]        bnd_raddr, bnd_waddr, bkt_raddr, bkt_waddr;
  logic signed [VAL_W-1:0] bnd_wdata;
  logic [CNT_W-1:0]        bkt_wdata;

  logic                    accept, cfg_wr, last;
  logic signed [VAL_W-1:0] in_clamped;
  logic signed [SUM_W:0]   sum_ext;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  chist_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_BUCKETS);
  assign prdata = (paddr[PADDR_W-1] == REG_BUCKETS) ? {{(32-CFG_W){1'b0}}, cfg_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      cfg_q <= pwdata[CFG_W-1:0];
    end
  end

  assign num_act = (NUM_W'(cfg_q) > NUM_W'(MAX_BUCKETS)) ? NUM_W'(MAX_BUCKETS)
                                                          : NUM_W'(cfg_q);

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign last        = (NUM_W'(cnt_q) == num_act - NUM_W'(1));
  assign in_clamped  = clamp_sample(in_data_i.value);
  assign sum_ext     = {sum_q[SUM_W-1], sum_q} + (SUM_W+1)'(in_clamped);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (in_data_i.op == OP_OBSERVE && num_act != '0) begin
            state_d = S_SCAN;
          end else if (in_data_i.op == OP_WRITE && in_data_i.index != '0 &&
                       in_range(in_data_i.value)) begin
            state_d = S_WCHK;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (last) begin
          state_d = S_RESP;
        end
      end
      S_WCHK: state_d = S_RESP;
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    val_d       = val_q;
    idx_d       = idx_q;
    op_d        = op_q;
    status_d    = status_q;
    total_d     = total_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    bnd_we      = 1'b0;
    bnd_waddr   = idx_q;
    bnd_wdata   = val_q;
    bnd_raddr   = idx_q;
    bkt_we      = 1'b0;
    bkt_waddr   = cnt_q;
    bkt_wdata   = alu_rsp.cnt_inc;
    bkt_raddr   = idx_q;
    bkt_clr     = 1'b0;
    alu_req.a   = val_q;
    alu_req.b   = bound_rd_q;
    alu_req.cnt = bucket_rd_q;

    unique case (state_q)
      S_IDLE: begin
        alu_req.cnt = total_q;
        if (accept) begin
          op_d     = in_data_i.op;
          idx_d    = in_data_i.index;
          val_d    = in_data_i.value;
          status_d = ST_OK;
          unique case (in_data_i.op)
            OP_OBSERVE: begin
              if (num_act == '0) begin
                status_d = ST_NO_BUCKETS;
              end else begin
                val_d     = in_clamped;
                total_d   = alu_rsp.cnt_inc;
                cnt_d     = '0;
                bnd_raddr = '0;
                bkt_raddr = '0;
                if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
                  sum_d = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                         : {1'b0, {(SUM_W-1){1'b1}}};
                end else begin
                  sum_d = sum_ext[SUM_W-1:0];
                end
              end
            end
            OP_WRITE: begin
              bnd_raddr = in_data_i.index - IDX_W'(1);
              bnd_waddr = in_data_i.index;
              bnd_wdata = in_data_i.value;
              if ((32'(in_data_i.index) >= 32'(MAX_BUCKETS)) ||
                  !in_range(in_data_i.value)) begin
                status_d = ST_BAD;
              end else if (in_data_i.index == '0) begin
                bnd_we = 1'b1;
              end
            end
            OP_READ: begin
              bkt_raddr = in_data_i.index;
              if (num_act == '0) begin
                status_d = ST_NO_BUCKETS;
              end else if (NUM_W'(in_data_i.index) >= num_act) begin
                status_d = ST_BAD;
              end
            end
            OP_CLEAR: begin
              bkt_clr = 1'b1;
              total_d = '0;
              sum_d   = '0;
            end
            default: status_d = ST_OK;
          endcase
        end
      end
      S_SCAN: begin
        bkt_we    = alu_rsp.le;
        bnd_raddr = cnt_q + IDX_W'(1);
        bkt_raddr = cnt_q + IDX_W'(1);
        cnt_d     = cnt_q + IDX_W'(1);
      end
      S_WCHK: begin
        if (alu_rsp.le) begin
          status_d = ST_BAD;
        end else begin
          bnd_we = 1'b1;
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_d.status       = status_q;
          out_d.total_count  = total_q;
          out_d.running_sum  = sum_q;
          out_d.bucket_value = (op_q == OP_READ && status_q == ST_OK) ? bucket_rd_q : '0;
        end
      end
      default: status_d = status_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    idx_q    <= idx_d;
    op_q     <= op_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (bnd_we) begin
      bound_mem[bnd_waddr] <= bnd_wdata;
    end
    bound_rd_q <= bound_mem[bnd_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (bkt_we) begin
      bucket_mem[bkt_waddr] <= bkt_wdata;
    end
    bucket_rd_q <= bkt_vld_q[bkt_raddr] ? bucket_mem[bkt_raddr] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bkt_vld_q <= '0;
    end else if (bkt_clr) begin
      bkt_vld_q <= '0;
    end else if (bkt_we) begin
      bkt_vld_q[bkt_waddr] <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> NUM_W'(cnt_q) < num_act)
    else $error("scan index beyond buckets in use");

  a_bucket_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bkt_we |-> state_q == S_SCAN)
    else $error("bucket write outside scan");

  a_total_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.op == OP_OBSERVE && num_act != '0 && !(&total_q)
    |=> total_q == $past(total_q) + CNT_W'(1))
    else $error("total count not raised on observe");

  a_resp_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESP && !(out_valid_q && out_stall_i)
    |=> out_valid_q && state_q == S_IDLE)
    else $error("result not loaded from response state");
`endif

endmodule
`default_nettype wire
